[rtl/skt_pkg.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman travel-time estimator: shared package
// Commands, widths, sequencer states and the command bundle passed from the
// top level to the bit-serial arithmetic unit.
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int unsigned FRAC_BITS_DEF  = 16;
	localparam int unsigned DELTA_BITS_DEF = 16;
	localparam int unsigned MAX_OBS_DEF    = 255;

	localparam int unsigned ACC_W = 64;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_PREDICT = 2'd1,
		CMD_UPDATE  = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Operations of the shared serial unit.
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1
	} op_t;

	// Sequencer states of the top level.
	typedef enum logic [4:0] {
		S_IDLE, S_ADD_MUL, S_ADD_W,
		S_PR_PM, S_PR_PMW, S_PR_FIRST, S_PR_FIRSTW,
		S_PR_PV, S_PR_PVW, S_PR_RAT, S_PR_RATW, S_PR_K, S_PR_KW,
		S_PR_POW, S_PR_POWW, S_PR_F2, S_PR_F2W, S_PR_B, S_PR_BW,
		S_PR_V1, S_PR_V1W, S_PR_V2, S_PR_V2W,
		S_UP_B, S_UP_BW, S_UP_E, S_UP_EW, S_UP_SQ, S_UP_SQW,
		S_UP_V, S_UP_VW, S_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		op_t               op;
		logic [ACC_W-1:0]  a;
		logic [ACC_W-1:0]  b;
		logic [6:0]        shift;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [ACC_W-1:0]  res;
	} alu_rsp_t;

	localparam logic [0:0] APB_ADDR_SEGLEN = 1'b0;

endpackage

[rtl/skt_alu.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman travel-time estimator: bit-serial arithmetic unit
// Shift-and-add multiply with right shift and saturation, and restoring
// division, both one bit per cycle on 64-bit operands.
// ----------------------------------------------------------------------------
module skt_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  skt_pkg::alu_req_t req,
	output skt_pkg::alu_rsp_t rsp
);
	import skt_pkg::*;

	logic              busy_q;
	op_t               op_q;
	logic [6:0]        cnt_q;
	logic [6:0]        sh_q;
	logic [ACC_W-1:0]  a_q;
	logic [ACC_W-1:0]  b_q;
	logic [2*ACC_W-1:0] prod_q;
	logic [ACC_W-1:0]  quo_q;
	logic [ACC_W:0]    rem_q;
	logic              done_q;
	logic [2*ACC_W-1:0] shifted;
	logic [2*ACC_W-1:0] addend;
	logic [ACC_W:0]    trial;

	// Multiplier bits come in from the top, so the partial sum shifts left.
	assign addend  = a_q[ACC_W-1] ? {{ACC_W{1'b0}}, b_q} : '0;
	assign trial   = {rem_q[ACC_W-1:0], a_q[ACC_W-1]};
	assign shifted = prod_q >> sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			a_q    <= req.a;
			b_q    <= req.b;
			sh_q   <= req.shift;
			prod_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[ACC_W-2:0], 1'b0};
			if (op_q == OP_MUL) begin
				prod_q <= (prod_q << 1) + addend;
			end else begin
				if (trial >= {1'b0, b_q}) begin
					rem_q <= trial - {1'b0, b_q};
					quo_q <= {quo_q[ACC_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[ACC_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.ovf  = 1'b0;
		if (op_q == OP_MUL) begin
			rsp.ovf = (shifted[2*ACC_W-1:ACC_W] != '0);
			rsp.res = rsp.ovf ? '1 : shifted[ACC_W-1:0];
		end else begin
			rsp.res = quo_q;
		end
	end

endmodule

[rtl/scalar_kalman_travel_time.sv]
// ----------------------------------------------------------------------------
// Scalar Kalman travel-time estimator: top level
// Holds the filter state, the configuration register and the sequencer that
// drives the shared serial arithmetic unit.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Every operation runs on the one
// bit-serial unit, which retires one bit per cycle; that unit sets the
// rate. An add-observation transaction takes one multiply for mean squared.
// An update takes six operations (three divisions for the mean, the mean
// square and the gain, and three multiplies). A first predict takes a
// division for the prior mean and one multiply. Any later predict takes the
// prior-mean division, the prior variance multiply, the ratio division and
// the division by 1000, then one squaring per bit of the elapsed time and
// one multiply per set bit (up to 2*DELTA_BITS operations), then four more
// multiplies: up to 8 + 2*DELTA_BITS operations. An update with nothing
// gathered and the unused command go straight to the done state. The state
// registers drive the result ports directly; the result is held until taken,
// and in_ready stays low while a transaction is in flight or its result is
// unread. segment_length sits at APB address 0 and reads back.
// ----------------------------------------------------------------------------
module scalar_kalman_travel_time #(
	parameter int unsigned FRAC_BITS  = skt_pkg::FRAC_BITS_DEF,
	parameter int unsigned DELTA_BITS = skt_pkg::DELTA_BITS_DEF,
	parameter int unsigned MAX_OBS    = skt_pkg::MAX_OBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] obs_mean,
	input  logic [47:0] obs_var,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] est_time,
	output logic [63:0] est_var,
	output logic [7:0]  pending_count
);
	import skt_pkg::*;

	localparam logic [7:0]  CAP      = (MAX_OBS > 255) ? 8'd255 : 8'(MAX_OBS);
	localparam logic [63:0] ONE_Q32  = 64'h1_0000_0000;
	localparam logic [63:0] HUNDRED  = 64'(100) << FRAC_BITS;
	localparam logic [63:0] DMAX     = (64'd1 << DELTA_BITS) - 64'd1;
	localparam logic [6:0]  FSH      = 7'(FRAC_BITS);
	localparam logic [64:0] MAX64    = {1'b0, {64{1'b1}}};

	state_t state_q, state_d;

	logic [15:0] seglen_q;
	logic [47:0] est_q;
	logic [63:0] var_q;
	logic [31:0] stamp_q;
	logic [7:0]  cnt_q;
	logic [23:0] msum_q;
	logic [63:0] ssum_q;

	logic [15:0] mean_q;
	logic [47:0] ovar_q;
	logic [31:0] now_q;

	// Work registers of the sequencer.
	logic [63:0] pm_q, pv_q, t0_q, t1_q, base_q, fn_q, fn2_q, eh_q, v1_q;
	logic [31:0] dl_q;
	logic        pw_sq_q;
	logic        tgt_ge_q;
	logic        is_up_q;

	alu_req_t req;
	alu_rsp_t rsp;
	logic     out_valid_q;

	logic [63:0]  sq_term;
	logic [63:0]  sq_sum_a;
	logic [63:0]  obs_v;
	logic [127:0] rp;

	skt_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign pready    = 1'b1;
	assign prdata    = {16'd0, seglen_q};
	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign est_time      = est_q;
	assign est_var       = var_q;
	assign pending_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seglen_q <= '0;
		end else if (psel && penable && pwrite && paddr == APB_ADDR_SEGLEN) begin
			seglen_q <= pwdata[15:0];
		end
	end

	// Ratio setup: halve both terms if their sum overflows, then shift v and
	// the sum right until the sum fits 32 bits. The shift follows from the
	// bit length of the sum.
	function automatic logic [127:0] ratio_prep(input logic [63:0] v, input logic [63:0] p);
		logic [63:0] vv, pp, s;
		logic [6:0]  len, k;
		vv = v;
		pp = p;
		if (v > ~p) begin
			vv = v >> 1;
			pp = p >> 1;
		end
		s = vv + pp;
		len = '0;
		for (int i = 0; i < 64; i++) begin
			if (s[i]) len = 7'(i + 1);
		end
		k = (len > 7'd32) ? len - 7'd32 : 7'd0;
		return {vv >> k, s >> k};
	endfunction

	always_comb begin
		unique case (state_q)
			S_PR_RAT: rp = ratio_prep(var_q, pv_q);
			default:  rp = ratio_prep(var_q, t0_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req       = '0;
		req.op    = OP_MUL;
		unique case (state_q)
			S_IDLE:      if (in_valid && in_ready) begin
				unique case (command)
					CMD_ADD:     state_d = S_ADD_MUL;
					CMD_PREDICT: state_d = S_PR_PM;
					// An update with nothing gathered changes nothing.
					CMD_UPDATE:  state_d = (cnt_q == '0) ? S_DONE : S_UP_B;
					default:     state_d = S_DONE;
				endcase
			end
			S_ADD_MUL: begin
				req.start = 1'b1;
				req.a = 64'(mean_q);
				req.b = 64'(mean_q);
				state_d = S_ADD_W;
			end
			S_PR_PM: begin
				req.start = 1'b1;
				req.op = OP_DIV;
				req.a = 64'(seglen_q) << FRAC_BITS;
				req.b = 64'd10;
				state_d = S_PR_PMW;
			end
			S_PR_FIRST: begin
				req.start = 1'b1;
				req.a = t0_q;
				req.b = t0_q;
				req.shift = FSH;
				state_d = S_PR_FIRSTW;
			end
			S_PR_PV: begin
				req.start = 1'b1;
				req.a = pm_q;
				req.b = pm_q;
				req.shift = FSH;
				state_d = S_PR_PVW;
			end
			S_PR_RAT, S_UP_V: begin
				req.start = 1'b1;
				req.op = OP_DIV;
				req.a = rp[127:64] << 32;
				req.b = rp[63:0];
				state_d = (state_q == S_PR_RAT) ? S_PR_RATW : S_UP_VW;
			end
			S_PR_K: begin
				req.start = 1'b1;
				req.op = OP_DIV;
				req.a = t0_q;
				req.b = 64'd1000;
				state_d = S_PR_KW;
			end
			S_PR_POW: begin
				req.start = 1'b1;
				req.a = pw_sq_q ? base_q : fn_q;
				req.b = base_q;
				req.shift = 7'd32;
				state_d = S_PR_POWW;
			end
			S_PR_F2: begin
				req.start = 1'b1;
				req.a = fn_q;
				req.b = fn_q;
				req.shift = 7'd32;
				state_d = S_PR_F2W;
			end
			S_PR_B, S_UP_SQ: begin
				req.start = 1'b1;
				req.a = t1_q;
				req.b = t0_q;
				req.shift = (state_q == S_UP_SQ) ? FSH : 7'd32;
				state_d = (state_q == S_UP_SQ) ? S_UP_SQW : S_PR_BW;
			end
			S_PR_V1: begin
				req.start = 1'b1;
				req.a = t0_q;
				req.b = var_q;
				req.shift = 7'd32;
				state_d = S_PR_V1W;
			end
			S_PR_V2: begin
				req.start = 1'b1;
				req.a = ONE_Q32 - t0_q;
				req.b = pv_q;
				req.shift = 7'd32;
				state_d = S_PR_V2W;
			end
			S_UP_B: begin
				req.start = 1'b1;
				req.op = OP_DIV;
				req.a = 64'(msum_q) << FRAC_BITS;
				req.b = 64'(cnt_q);
				state_d = S_UP_BW;
			end
			S_UP_E: begin
				req.start = 1'b1;
				req.op = OP_DIV;
				req.a = ssum_q;
				req.b = 64'(cnt_q);
				state_d = S_UP_EW;
			end
			S_DONE: state_d = S_IDLE;
			default: if (rsp.done) begin
				unique case (state_q)
					S_ADD_W:     state_d = S_DONE;
					S_PR_PMW:    state_d = (stamp_q == '0) ? S_PR_FIRST : S_PR_PV;
					S_PR_FIRSTW: state_d = S_DONE;
					S_PR_PVW:    state_d = S_PR_RAT;
					S_PR_RATW:   state_d = S_PR_K;
					S_PR_KW:     state_d = (dl_q == '0) ? S_PR_F2 : S_PR_POW;
					// The series ends once the squaring has consumed the
					// last remaining bit of the elapsed time.
					S_PR_POWW:   state_d = (pw_sq_q && dl_q[31:1] == '0) ? S_PR_F2 : S_PR_POW;
					S_PR_F2W:    state_d = S_PR_B;
					S_PR_BW:     state_d = S_PR_V1;
					S_PR_V1W:    state_d = is_up_q ? S_DONE : S_PR_V2;
					S_PR_V2W:    state_d = S_DONE;
					S_UP_BW:     state_d = S_UP_E;
					S_UP_EW:     state_d = S_UP_SQ;
					S_UP_SQW:    state_d = S_UP_V;
					S_UP_VW:     state_d = S_PR_B;
					default:     state_d = S_IDLE;
				endcase
			end
		endcase
	end

	// The blend step S_PR_B is shared: in a predict t1 holds fn, in an
	// update t1 holds the gain. S_PR_V1 is shared too: in a predict it scales
	// the variance by fn squared, in an update by one minus the gain.
	assign sq_term = rsp.res << FRAC_BITS;
	assign obs_v   = (ovar_q == '0) ? HUNDRED : 64'(ovar_q);

	always_comb begin
		sq_sum_a = ({1'b0, ssum_q} + {1'b0, sq_term} > MAX64) ? '1 : ssum_q + sq_term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			est_q  <= '0;
			var_q  <= '0;
			stamp_q <= '0;
			cnt_q  <= '0;
			msum_q <= '0;
			ssum_q <= '0;
		end else begin
			if (state_q == S_DONE) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			// A full accumulator drops further observations.
			if (state_q == S_ADD_W && rsp.done && cnt_q < CAP) begin
				cnt_q  <= cnt_q + 8'd1;
				msum_q <= ({1'b0, msum_q} + 25'(mean_q) > 25'hFF_FFFF) ? 24'hFF_FFFF
					: msum_q + 24'(mean_q);
				ssum_q <= ({1'b0, sq_sum_a} + {1'b0, obs_v} > MAX64) ? '1
					: sq_sum_a + obs_v;
			end
			if (state_q == S_PR_FIRSTW && rsp.done) begin
				var_q   <= rsp.res;
				stamp_q <= now_q;
			end
			if (state_q == S_PR_FIRST) est_q <= t0_q[47:0];
			if (state_q == S_PR_BW && rsp.done) begin
				est_q <= tgt_ge_q ? 48'(pm_q + rsp.res) : 48'(pm_q - rsp.res);
			end
			if (state_q == S_PR_V1W && rsp.done && is_up_q) begin
				var_q  <= rsp.res;
				cnt_q  <= '0;
				msum_q <= '0;
				ssum_q <= '0;
			end
			if (state_q == S_PR_V2W && rsp.done) begin
				var_q <= ({1'b0, v1_q} + {1'b0, rsp.res} > MAX64)
					? '1 : v1_q + rsp.res;
				stamp_q <= now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && in_ready) begin
			mean_q <= obs_mean;
			ovar_q <= obs_var;
			now_q  <= now_time;
			is_up_q <= (command == CMD_UPDATE);
		end
		if (state_q == S_PR_V1W && rsp.done) v1_q <= rsp.res;
		if (rsp.done) begin
			unique case (state_q)
				S_PR_PMW: begin
					pm_q <= (seglen_q != '0) ? rsp.res : 64'(est_q);
					t0_q <= (seglen_q != '0) ? ((rsp.res == '0) ? HUNDRED : rsp.res)
						: ((est_q == '0) ? HUNDRED : 64'(est_q));
					dl_q <= (now_q >= stamp_q)
						? (((64'(now_q - stamp_q)) > DMAX) ? DMAX[31:0] : now_q - stamp_q)
						: '0;
				end
				S_PR_PVW:  pv_q <= rsp.res;
				S_PR_RATW: t0_q <= rsp.res;
				S_PR_KW: begin
					base_q  <= ONE_Q32 - rsp.res;
					fn_q    <= ONE_Q32;
					pw_sq_q <= ~dl_q[0];
				end
				S_PR_POWW: begin
					if (pw_sq_q) begin
						base_q  <= rsp.res;
						pw_sq_q <= ~dl_q[1];
						dl_q    <= dl_q >> 1;
					end else begin
						fn_q    <= rsp.res;
						pw_sq_q <= 1'b1;
					end
				end
				S_PR_F2W: begin
					t1_q     <= fn_q;
					t0_q     <= (64'(est_q) >= pm_q) ? 64'(est_q) - pm_q : pm_q - 64'(est_q);
					tgt_ge_q <= (64'(est_q) >= pm_q);
					fn2_q    <= rsp.res;
				end
				S_PR_BW:   t0_q <= is_up_q ? ONE_Q32 - t1_q : fn2_q;
				S_UP_BW:   pm_q <= rsp.res;
				S_UP_EW:   begin
					t1_q <= pm_q;
					t0_q <= pm_q;
					eh_q <= rsp.res;
				end
				S_UP_SQW:  t0_q <= (eh_q > rsp.res) ? eh_q - rsp.res : '0;
				S_UP_VW: begin
					t1_q     <= rsp.res;
					t0_q     <= (pm_q >= 64'(est_q)) ? pm_q - 64'(est_q) : 64'(est_q) - pm_q;
					tgt_ge_q <= (pm_q >= 64'(est_q));
				end
				default: ;
			endcase
		end
		if (state_q == S_UP_VW && rsp.done) pm_q <= 64'(est_q);
	end

endmodule
